/* rtl/irtx_pkg.sv */
// Shared types, codes and constants of the infrared remote frame transmitter.
// No dependencies; used by irtx_engine and infrared_remote_frame_transmitter.
package irtx_pkg;

   // Width of every timing register and of the segment timer.
   localparam int TIME_WIDTH = 14;

   // Item commands.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_FULL   = 2'd1;
   localparam logic [1:0] CMD_REPEAT = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   // Frame phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LMARK  = 3'd1;
   localparam logic [2:0] PH_LSPACE = 3'd2;
   localparam logic [2:0] PH_BMARK  = 3'd3;
   localparam logic [2:0] PH_BSPACE = 3'd4;
   localparam logic [2:0] PH_STOP   = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_LEADER_MARK  = 3'd0;
   localparam logic [2:0] REG_LEADER_SPACE = 3'd1;
   localparam logic [2:0] REG_REPEAT_SPACE = 3'd2;
   localparam logic [2:0] REG_BIT_MARK     = 3'd3;
   localparam logic [2:0] REG_ONE_SPACE    = 3'd4;
   localparam logic [2:0] REG_ZERO_SPACE   = 3'd5;
   localparam logic [2:0] REG_ADDRESS      = 3'd6;
   localparam logic [2:0] REG_SEND_INVERSE = 3'd7;

   // Register reset values.
   localparam logic [TIME_WIDTH-1:0] RST_LEADER_MARK  = TIME_WIDTH'(9000);
   localparam logic [TIME_WIDTH-1:0] RST_LEADER_SPACE = TIME_WIDTH'(4500);
   localparam logic [TIME_WIDTH-1:0] RST_REPEAT_SPACE = TIME_WIDTH'(2250);
   localparam logic [TIME_WIDTH-1:0] RST_BIT_MARK     = TIME_WIDTH'(560);
   localparam logic [TIME_WIDTH-1:0] RST_ONE_SPACE    = TIME_WIDTH'(560);
   localparam logic [TIME_WIDTH-1:0] RST_ZERO_SPACE   = TIME_WIDTH'(1690);
   localparam logic [15:0]           RST_ADDRESS      = 16'd255;
   localparam logic                  RST_SEND_INVERSE = 1'b1;

   // Bit counts of a frame with and without the inverted data byte.
   localparam logic [5:0] FULL_BITS  = 6'd32;
   localparam logic [5:0] SHORT_BITS = 6'd24;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] leader_mark_us;
      logic [TIME_WIDTH-1:0] leader_space_us;
      logic [TIME_WIDTH-1:0] repeat_space_us;
      logic [TIME_WIDTH-1:0] bit_mark_us;
      logic [TIME_WIDTH-1:0] one_space_us;
      logic [TIME_WIDTH-1:0] zero_space_us;
      logic [15:0]           address_word;
      logic                  send_inverse;
   } cfg_type;

   typedef struct packed {
      logic mark_on;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_type;

endpackage

/* rtl/irtx_engine.sv */
// Frame sequencer: phase, segment timer and bit shifter, one item per step.
// Depends on irtx_pkg for codes, the configuration struct and the result struct.
module irtx_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [1:0]        cmd,
   input  logic [7:0]        code_byte,
   input  irtx_pkg::cfg_type cfg,
   output irtx_pkg::rsp_type res
);

   logic [2:0]                      phase_ff, phase_in;
   logic [irtx_pkg::TIME_WIDTH-1:0] remain_ff, remain_in;
   logic [31:0]                     bits_ff, bits_in;
   logic [5:0]                      left_ff, left_in;
   logic                            rep_ff, rep_in;
   logic                            busy;
   logic                            level;

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      bits_in   = bits_ff;
      left_in   = left_ff;
      rep_in    = rep_ff;
      res       = '0;
      busy      = (phase_ff != irtx_pkg::PH_IDLE);
      level     = (phase_ff == irtx_pkg::PH_LMARK) || (phase_ff == irtx_pkg::PH_BMARK) ||
                  (phase_ff == irtx_pkg::PH_STOP);

      case (cmd)
         irtx_pkg::CMD_TICK: begin
            if (busy) begin
               res.mark_on  = level;
               res.busy_res = 1'b1;
               if (remain_ff <= irtx_pkg::TIME_WIDTH'(1)) begin
                  // last microsecond of the segment: advance
                  case (phase_ff)
                     irtx_pkg::PH_LMARK: begin
                        phase_in  = irtx_pkg::PH_LSPACE;
                        remain_in = rep_ff ? cfg.repeat_space_us : cfg.leader_space_us;
                     end
                     irtx_pkg::PH_LSPACE: begin
                        if (rep_ff) begin
                           phase_in       = irtx_pkg::PH_IDLE;
                           remain_in      = '0;
                           res.frame_done = 1'b1;
                        end else if (left_ff == 6'd0) begin
                           phase_in  = irtx_pkg::PH_STOP;
                           remain_in = cfg.bit_mark_us;
                        end else begin
                           phase_in  = irtx_pkg::PH_BMARK;
                           remain_in = cfg.bit_mark_us;
                        end
                     end
                     irtx_pkg::PH_BMARK: begin
                        phase_in  = irtx_pkg::PH_BSPACE;
                        remain_in = bits_ff[0] ? cfg.one_space_us : cfg.zero_space_us;
                     end
                     irtx_pkg::PH_BSPACE: begin
                        bits_in   = {1'b0, bits_ff[31:1]};
                        left_in   = left_ff - 6'd1;
                        phase_in  = (left_in == 6'd0) ? irtx_pkg::PH_STOP : irtx_pkg::PH_BMARK;
                        remain_in = cfg.bit_mark_us;
                     end
                     default: begin
                        phase_in       = irtx_pkg::PH_IDLE;
                        remain_in      = '0;
                        res.frame_done = 1'b1;
                     end
                  endcase
               end else begin
                  remain_in = remain_ff - irtx_pkg::TIME_WIDTH'(1);
               end
            end
         end
         irtx_pkg::CMD_FULL, irtx_pkg::CMD_REPEAT: begin
            res.busy_res = 1'b1;
            if (busy) begin
               res.rejected = 1'b1;
               res.mark_on  = level;
            end else begin
               rep_in = (cmd == irtx_pkg::CMD_REPEAT);
               if (cmd == irtx_pkg::CMD_FULL) begin
                  bits_in = {(cfg.send_inverse ? ~code_byte : 8'h00), code_byte,
                             cfg.address_word};
                  left_in = cfg.send_inverse ? irtx_pkg::FULL_BITS : irtx_pkg::SHORT_BITS;
               end else begin
                  bits_in = '0;
                  left_in = '0;
               end
               phase_in    = irtx_pkg::PH_LMARK;
               remain_in   = cfg.leader_mark_us;
               res.mark_on = 1'b1;
            end
         end
         default: begin
            res.mark_on  = busy && level;
            res.busy_res = busy;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= irtx_pkg::PH_IDLE;
         remain_ff <= '0;
         bits_ff   <= '0;
         left_ff   <= '0;
         rep_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         bits_ff   <= bits_in;
         left_ff   <= left_in;
         rep_ff    <= rep_in;
      end
   end

endmodule

/* rtl/infrared_remote_frame_transmitter.sv */
// Top level of the pulse-distance infrared remote frame transmitter.
// Holds the control registers, the item input register and the result register;
// depends on irtx_pkg and irtx_engine.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_cmd, req_code_byte
//   rsp_      out        rsp_valid/rsp_ready  rsp_mark_on, rsp_busy_res,
//                                             rsp_frame_done, rsp_rejected
//   csr_      in/out     csr_psel/csr_penable csr_paddr, csr_pwdata, csr_prdata
//
// One item per clock cycle sustained while results are taken; an accepted item
// passes the input register, the sequencer logic and then the result register,
// where its result lands. The rate is set by the frame sequencer updating its
// phase and segment timer once per item.
// Synchronous active-high reset idles the sequencer and loads register defaults.
// A stalled result holds in the result register; the input register keeps taking
// items until it too is full, then req_ready drops.
module infrared_remote_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_mark_on,
   output logic        rsp_busy_res,
   output logic        rsp_frame_done,
   output logic        rsp_rejected,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   irtx_pkg::cfg_type cfg_ff;
   logic              hold_valid_ff;
   logic [1:0]        hold_cmd_ff;
   logic [7:0]        hold_code_ff;
   logic              rsp_valid_ff;
   irtx_pkg::rsp_type rsp_ff;
   irtx_pkg::rsp_type eng_res;
   logic              advance;
   logic              cfg_write;
   logic [2:0]        reg_index;

   // Control registers: written on the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark_us  <= irtx_pkg::RST_LEADER_MARK;
         cfg_ff.leader_space_us <= irtx_pkg::RST_LEADER_SPACE;
         cfg_ff.repeat_space_us <= irtx_pkg::RST_REPEAT_SPACE;
         cfg_ff.bit_mark_us     <= irtx_pkg::RST_BIT_MARK;
         cfg_ff.one_space_us    <= irtx_pkg::RST_ONE_SPACE;
         cfg_ff.zero_space_us   <= irtx_pkg::RST_ZERO_SPACE;
         cfg_ff.address_word    <= irtx_pkg::RST_ADDRESS;
         cfg_ff.send_inverse    <= irtx_pkg::RST_SEND_INVERSE;
      end else if (cfg_write) begin
         case (reg_index)
            irtx_pkg::REG_LEADER_MARK:
               cfg_ff.leader_mark_us  <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_LEADER_SPACE:
               cfg_ff.leader_space_us <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_REPEAT_SPACE:
               cfg_ff.repeat_space_us <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_BIT_MARK:
               cfg_ff.bit_mark_us     <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_ONE_SPACE:
               cfg_ff.one_space_us    <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_ZERO_SPACE:
               cfg_ff.zero_space_us   <= csr_pwdata[irtx_pkg::TIME_WIDTH-1:0];
            irtx_pkg::REG_ADDRESS:
               cfg_ff.address_word    <= csr_pwdata[15:0];
            default:
               cfg_ff.send_inverse    <= csr_pwdata[0];
         endcase
      end
   end

   // Read back the addressed register, zero extended.
   always_comb begin
      case (reg_index)
         irtx_pkg::REG_LEADER_MARK:  csr_prdata = 32'(cfg_ff.leader_mark_us);
         irtx_pkg::REG_LEADER_SPACE: csr_prdata = 32'(cfg_ff.leader_space_us);
         irtx_pkg::REG_REPEAT_SPACE: csr_prdata = 32'(cfg_ff.repeat_space_us);
         irtx_pkg::REG_BIT_MARK:     csr_prdata = 32'(cfg_ff.bit_mark_us);
         irtx_pkg::REG_ONE_SPACE:    csr_prdata = 32'(cfg_ff.one_space_us);
         irtx_pkg::REG_ZERO_SPACE:   csr_prdata = 32'(cfg_ff.zero_space_us);
         irtx_pkg::REG_ADDRESS:      csr_prdata = 32'(cfg_ff.address_word);
         default:                    csr_prdata = 32'(cfg_ff.send_inverse);
      endcase
   end

   // The held item goes through the sequencer when the result register is free
   // or being emptied this cycle.
   assign advance   = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hold_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hold_valid_ff <= req_valid;
      end
   end

   // Capture the item payload whenever the input register takes a new item.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_cmd_ff  <= req_cmd;
         hold_code_ff <= req_code_byte;
      end
   end

   irtx_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (hold_cmd_ff),
      .code_byte (hold_code_ff),
      .cfg       (cfg_ff),
      .res       (eng_res)
   );

   // Result register: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= eng_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mark_on    = rsp_ff.mark_on;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_rejected   = rsp_ff.rejected;

endmodule
